// File: rtl/core/uvs_pkg.sv
package uvs_pkg;

	localparam int ANGLE_FRAC_BITS_DEF = 16;

	// Divisor width: twice a count of up to 255
	localparam int DIV_DW = 9;

	// Reset values of the configuration registers
	localparam logic [7:0]  STACK_COUNT_RST  = 8'd16;
	localparam logic [7:0]  SECTOR_COUNT_RST = 8'd32;
	localparam logic [14:0] RADIUS_RST       = 15'd256;

	// Odd Taylor terms of sin(pi/2 * x), Q30
	localparam logic [30:0] COEF1 = 31'd1686629713;
	localparam logic [30:0] COEF3 = 31'd693598670;
	localparam logic [30:0] COEF5 = 31'd85569305;
	localparam logic [30:0] COEF7 = 31'd5026994;
	localparam logic [30:0] COEF9 = 31'd172272;

	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef enum logic [1:0] {
		CFG_STACK_COUNT  = 2'd0,
		CFG_SECTOR_COUNT = 2'd1,
		CFG_RADIUS       = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  stack_count;
		logic [7:0]  sector_count;
		logic [14:0] radius;
	} cfg_t;

	// One classified grid point, counts already clamped to their minimum
	typedef struct packed {
		logic       bad;
		logic [7:0] i;
		logic [7:0] j;
		logic [7:0] nst;
		logic [7:0] nse;
	} item_t;

endpackage

// File: rtl/core/uv_sphere_vertex_generator_core.sv
// Channel  | Direction | Handshake          | Payload
// ---------+-----------+--------------------+-------------------------------------
// in       | sink      | in_valid/in_stall  | stack_index, sector_index
// out      | source    | out_valid/out_stall| pos_x/y/z, norm_x/y/z, tex_u/v, bad_index
// cfg      | sink      | cfg_wen            | cfg_index, cfg_wdata
//
// One vertex per cycle sustained while out_stall stays low. Pipeline depth is
// set by the bit-per-stage dividers and the seven-stage sine polynomial.
// Reset (arst_n low) clears all valid flags and loads the register defaults.
// out_stall freezes the back pipeline; the two-entry queue lets the front keep
// taking transfers until it fills, then in_stall rises.
module uv_sphere_vertex_generator_core #(
	parameter int ANGLE_FRAC_BITS = uvs_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration writes
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_wdata,
	// grid point in
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  stack_index,
	input  logic [7:0]  sector_index,
	// vertex out
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pos_x,
	output logic [15:0] pos_y,
	output logic [15:0] pos_z,
	output logic [15:0] norm_x,
	output logic [15:0] norm_y,
	output logic [15:0] norm_z,
	output logic [15:0] tex_u,
	output logic [15:0] tex_v,
	output logic        bad_index
);

	uvs_pkg::cfg_t  cfg_q;
	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           q_valid;
	uvs_pkg::item_t q_wr_item;
	uvs_pkg::item_t q_rd_item;

	// register file; unknown index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stack_count  <= uvs_pkg::STACK_COUNT_RST;
			cfg_q.sector_count <= uvs_pkg::SECTOR_COUNT_RST;
			cfg_q.radius       <= uvs_pkg::RADIUS_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				uvs_pkg::CFG_STACK_COUNT:  cfg_q.stack_count  <= cfg_wdata[7:0];
				uvs_pkg::CFG_SECTOR_COUNT: cfg_q.sector_count <= cfg_wdata[7:0];
				uvs_pkg::CFG_RADIUS:       cfg_q.radius       <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// front: accept, clamp counts, range check
	uvs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.stack_index  (stack_index),
		.sector_index (sector_index),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_wr_item)
	);

	// decoupling queue between front and back
	uvs_fifo #(.WIDTH($bits(uvs_pkg::item_t)), .DEPTH(2)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_wr_item),
		.pop       (q_pop),
		.rdata     (q_rd_item),
		.full      (q_full),
		.not_empty (q_valid)
	);

	// back: dividers, sines, products, output register
	uvs_back #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_valid),
		.q_item    (q_rd_item),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.norm_x    (norm_x),
		.norm_y    (norm_y),
		.norm_z    (norm_z),
		.tex_u     (tex_u),
		.tex_v     (tex_v),
		.bad_index (bad_index)
	);

	// flagged vertices carry all-zero payload
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_index |-> pos_x == '0 && pos_y == '0 && pos_z == '0 &&
			norm_x == '0 && tex_u == '0 && tex_v == '0)
		else $error("bad_index with nonzero payload");

	// normals stay within unit range
	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ($signed(norm_y) <= 16'sd16384) && ($signed(norm_y) >= -16'sd16384))
		else $error("norm_y out of range");

	// texture coordinates never exceed one
	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> tex_u <= 16'd32768 && tex_v <= 16'd32768)
		else $error("tex coordinate out of range");

	// write to an unknown index leaves the registers alone
	a_cfg_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wen && cfg_index > uvs_pkg::CFG_RADIUS |=> $stable(cfg_q))
		else $error("unknown register index changed config");

endmodule

// File: rtl/core/uvs_fifo.sv
module uvs_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             not_empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/core/uvs_front.sv
module uvs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  uvs_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    stack_index,
	input  logic [7:0]    sector_index,
	input  logic          q_full,
	output logic          q_push,
	output uvs_pkg::item_t q_item
);

	logic           vld_s1;
	uvs_pkg::item_t item_s1;
	uvs_pkg::item_t item_d;
	logic           accept;

	assign in_stall = vld_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = vld_s1 && !q_full;
	assign q_item   = item_s1;

	// clamp counts to their minimum, flag out-of-range indices
	always_comb begin
		item_d.i   = stack_index;
		item_d.j   = sector_index;
		item_d.nst = (cfg.stack_count < 8'd2) ? 8'd2 : cfg.stack_count;
		item_d.nse = (cfg.sector_count < 8'd3) ? 8'd3 : cfg.sector_count;
		item_d.bad = (stack_index > item_d.nst) || (sector_index > item_d.nse);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (q_push) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// File: rtl/core/uvs_div.sv
module uvs_div #(
	parameter int QW = 17,
	parameter int DW = 9
) (
	input  logic             clk,
	input  logic             en,
	input  logic [QW+DW-1:0] num,
	input  logic [DW-1:0]    den,
	output logic [QW-1:0]    quot
);

	// one quotient bit per stage; numerator must be below den * 2^QW
	logic [DW-1:0] rem_q  [QW];
	logic [QW-1:0] low_q  [QW];
	logic [QW-1:0] quo_q  [QW];
	logic [DW-1:0] den_q  [QW];
	logic [DW-1:0] rem_d  [QW];
	logic [QW-1:0] low_d  [QW];
	logic [QW-1:0] quo_d  [QW];
	logic [DW-1:0] den_d  [QW];

	always_comb begin
		for (int k = 0; k < QW; k++) begin
			logic [DW-1:0] rin;
			logic [QW-1:0] lin;
			logic [QW-1:0] qin;
			logic [DW-1:0] din;
			logic [DW:0]   trial;
			logic [DW:0]   diff;
			logic          ge;
			if (k == 0) begin
				rin = num[QW+DW-1:QW];
				lin = num[QW-1:0];
				qin = '0;
				din = den;
			end else begin
				rin = rem_q[k-1];
				lin = low_q[k-1];
				qin = quo_q[k-1];
				din = den_q[k-1];
			end
			trial = {rin, lin[QW-1-k]};
			diff  = trial - {1'b0, din};
			ge    = (trial >= {1'b0, din});
			rem_d[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
			low_d[k] = lin;
			quo_d[k] = qin | (QW'(ge) << (QW-1-k));
			den_d[k] = din;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_q[k] <= rem_d[k];
				low_q[k] <= low_d[k];
				quo_q[k] <= quo_d[k];
				den_q[k] <= den_d[k];
			end
		end
	end

	assign quot = quo_q[QW-1];

endmodule

// File: rtl/core/uvs_sine.sv
module uvs_sine #(
	parameter int ANGLE_FRAC_BITS = uvs_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ANGLE_FRAC_BITS-1:0] ph,
	output logic [30:0]                mag,
	output logic                       neg
);

	localparam int A = ANGLE_FRAC_BITS;
	localparam logic [A-2:0] QTR = (A-1)'(1) << (A-2);

	logic [A-2:0] xq;
	logic [30:0]  x_d;

	logic [30:0] x_s1, x_s2, x_s3, x_s4, x_s5, x_s6;
	logic [30:0] x2_s2, x2_s3, x2_s4, x2_s5;
	logic [30:0] t_s3, t_s4, t_s5, t_s6;
	logic [30:0] m_s7;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;

	logic [61:0] p2, p3, p4, p5, p6, p7;

	// fold to first quadrant, scale offset to Q30
	assign xq  = ph[A-2] ? (QTR - {1'b0, ph[A-3:0]}) : {1'b0, ph[A-3:0]};
	assign x_d = {xq, (32-A)'(0)};

	assign p2 = 62'(x_s1) * 62'(x_s1);
	assign p3 = 62'(uvs_pkg::COEF9) * 62'(x2_s2);
	assign p4 = 62'(t_s3) * 62'(x2_s3);
	assign p5 = 62'(t_s4) * 62'(x2_s4);
	assign p6 = 62'(t_s5) * 62'(x2_s5);
	assign p7 = 62'(t_s6) * 62'(x_s6);

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_d;
			neg_s1 <= ph[A-1];

			x2_s2  <= p2[60:30];
			x_s2   <= x_s1;
			neg_s2 <= neg_s1;

			t_s3   <= uvs_pkg::COEF7 - p3[60:30];
			x2_s3  <= x2_s2;
			x_s3   <= x_s2;
			neg_s3 <= neg_s2;

			t_s4   <= uvs_pkg::COEF5 - p4[60:30];
			x2_s4  <= x2_s3;
			x_s4   <= x_s3;
			neg_s4 <= neg_s3;

			t_s5   <= uvs_pkg::COEF3 - p5[60:30];
			x2_s5  <= x2_s4;
			x_s5   <= x_s4;
			neg_s5 <= neg_s4;

			t_s6   <= uvs_pkg::COEF1 - p6[60:30];
			x_s6   <= x_s5;
			neg_s6 <= neg_s5;

			m_s7   <= (p7[60:30] > uvs_pkg::Q30_ONE) ? uvs_pkg::Q30_ONE : p7[60:30];
			neg_s7 <= neg_s6;
		end
	end

	assign mag = m_s7;
	assign neg = neg_s7;

endmodule

// File: rtl/core/uvs_back.sv
module uvs_back #(
	parameter int ANGLE_FRAC_BITS = uvs_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  uvs_pkg::cfg_t  cfg,
	input  logic           q_valid,
	input  uvs_pkg::item_t q_item,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [15:0]    pos_x,
	output logic [15:0]    pos_y,
	output logic [15:0]    pos_z,
	output logic [15:0]    norm_x,
	output logic [15:0]    norm_y,
	output logic [15:0]    norm_z,
	output logic [15:0]    tex_u,
	output logic [15:0]    tex_v,
	output logic           bad_index
);

	localparam int A   = ANGLE_FRAC_BITS;
	localparam int DW  = uvs_pkg::DIV_DW;
	localparam int DQ  = (A + 1 > 16) ? A + 1 : 16;
	localparam int NW  = DQ + DW;
	localparam int LAT = DQ + 8;
	localparam logic [A-1:0] QTR  = A'(1) << (A-2);
	localparam logic [A-1:0] HALF = A'(1) << (A-1);

	logic en;
	logic [NW-1:0] num_sec, num_pol, num_tu, num_tv;
	logic [DW-1:0] den_se, den_st;
	logic [DQ-1:0] q_sec, q_pol, q_tu, q_tv;
	logic [A-1:0]  ph_sin_se, ph_cos_se, ph_sin_st, ph_cos_st;
	logic [30:0]   m_sin_st, m_cos_st, m_sin_se, m_cos_se;
	logic          n_sin_st, n_cos_st, n_sin_se, n_cos_se;

	logic          vld_pipe_q [LAT];
	logic          bad_pipe_q [LAT];
	logic [15:0]   tu_pipe_q  [8];
	logic [15:0]   tv_pipe_q  [8];

	logic [30:0]   dx_s8, dz_s8, sy_s8;
	logic          dxn_s8, dzn_s8, syn_s8;
	logic [61:0]   px, pz;

	assign en    = !out_valid || !out_stall;
	assign q_pop = en && q_valid;

	// rounded quotients: (idx*2^k + n) / (2n)
	assign den_se  = {q_item.nse, 1'b0};
	assign den_st  = {q_item.nst, 1'b0};
	assign num_sec = (NW'(q_item.j) << (A + 1)) + NW'(q_item.nse);
	assign num_pol = (NW'(q_item.i) << A) + NW'(q_item.nst);
	assign num_tu  = (NW'(q_item.j) << 16) + NW'(q_item.nse);
	assign num_tv  = (NW'(q_item.i) << 16) + NW'(q_item.nst);

	uvs_div #(.QW(DQ), .DW(DW)) u_div_sec (
		.clk(clk), .en(en), .num(num_sec), .den(den_se), .quot(q_sec));
	uvs_div #(.QW(DQ), .DW(DW)) u_div_pol (
		.clk(clk), .en(en), .num(num_pol), .den(den_st), .quot(q_pol));
	uvs_div #(.QW(DQ), .DW(DW)) u_div_tu (
		.clk(clk), .en(en), .num(num_tu), .den(den_se), .quot(q_tu));
	uvs_div #(.QW(DQ), .DW(DW)) u_div_tv (
		.clk(clk), .en(en), .num(num_tv), .den(den_st), .quot(q_tv));

	assign ph_sin_se = q_sec[A-1:0];
	assign ph_cos_se = q_sec[A-1:0] + QTR;
	assign ph_sin_st = QTR - q_pol[A-1:0];
	assign ph_cos_st = HALF - q_pol[A-1:0];

	uvs_sine #(.ANGLE_FRAC_BITS(A)) u_sin_st (
		.clk(clk), .en(en), .ph(ph_sin_st), .mag(m_sin_st), .neg(n_sin_st));
	uvs_sine #(.ANGLE_FRAC_BITS(A)) u_cos_st (
		.clk(clk), .en(en), .ph(ph_cos_st), .mag(m_cos_st), .neg(n_cos_st));
	uvs_sine #(.ANGLE_FRAC_BITS(A)) u_sin_se (
		.clk(clk), .en(en), .ph(ph_sin_se), .mag(m_sin_se), .neg(n_sin_se));
	uvs_sine #(.ANGLE_FRAC_BITS(A)) u_cos_se (
		.clk(clk), .en(en), .ph(ph_cos_se), .mag(m_cos_se), .neg(n_cos_se));

	assign px = 62'(m_cos_st) * 62'(m_cos_se) + 62'(32'h2000_0000);
	assign pz = 62'(m_cos_st) * 62'(m_sin_se) + 62'(32'h2000_0000);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++) begin
				vld_pipe_q[k] <= 1'b0;
			end
		end else if (en) begin
			vld_pipe_q[0] <= q_valid;
			for (int k = 1; k < LAT; k++) begin
				vld_pipe_q[k] <= vld_pipe_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_pipe_q[0] <= q_item.bad;
			for (int k = 1; k < LAT; k++) begin
				bad_pipe_q[k] <= bad_pipe_q[k-1];
			end
			tu_pipe_q[0] <= q_tu[15:0];
			tv_pipe_q[0] <= q_tv[15:0];
			for (int k = 1; k < 8; k++) begin
				tu_pipe_q[k] <= tu_pipe_q[k-1];
				tv_pipe_q[k] <= tv_pipe_q[k-1];
			end
			dx_s8  <= px[60:30];
			dz_s8  <= pz[60:30];
			dxn_s8 <= n_cos_st ^ n_cos_se;
			dzn_s8 <= n_cos_st ^ n_sin_se;
			sy_s8  <= m_sin_st;
			syn_s8 <= n_sin_st;
		end
	end

	function automatic logic [15:0] to_pos(logic [14:0] r, logic [30:0] m, logic n);
		logic [45:0] p;
		p = 46'(r) * 46'(m) + 46'(32'h2000_0000);
		return n ? (16'd0 - p[45:30]) : p[45:30];
	endfunction

	function automatic logic [15:0] to_norm(logic [30:0] m, logic n);
		logic [31:0] s;
		s = 32'(m) + 32'h0000_8000;
		return n ? (16'd0 - s[31:16]) : s[31:16];
	endfunction

	logic bad_l;
	assign bad_l = bad_pipe_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_pipe_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bad_index <= bad_l;
			pos_x  <= bad_l ? '0 : to_pos(cfg.radius, dx_s8, dxn_s8);
			pos_y  <= bad_l ? '0 : to_pos(cfg.radius, sy_s8, syn_s8);
			pos_z  <= bad_l ? '0 : to_pos(cfg.radius, dz_s8, dzn_s8);
			norm_x <= bad_l ? '0 : to_norm(dx_s8, dxn_s8);
			norm_y <= bad_l ? '0 : to_norm(sy_s8, syn_s8);
			norm_z <= bad_l ? '0 : to_norm(dz_s8, dzn_s8);
			tex_u  <= bad_l ? '0 : tu_pipe_q[7];
			tex_v  <= bad_l ? '0 : tv_pipe_q[7];
		end
	end

endmodule

// File: test/uvs_vertex_checker.sv
module uvs_vertex_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_index,
	input  logic [14:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  stack_index,
	input  logic [7:0]  sector_index,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [15:0] pos_x,
	input  logic [15:0] pos_y,
	input  logic [15:0] pos_z,
	input  logic [15:0] norm_x,
	input  logic [15:0] norm_y,
	input  logic [15:0] norm_z,
	input  logic [15:0] tex_u,
	input  logic [15:0] tex_v,
	input  logic        bad_index,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ANG = uvs_pkg::ANGLE_FRAC_BITS_DEF;
	localparam longint unsigned FULL = 64'd1 << ANG;
	localparam longint unsigned QTR = FULL >> 2;

	typedef struct packed {
		logic [15:0] px, py, pz, nx, ny, nz, u, v;
		logic        bad;
	} vertex_t;

	vertex_t     vertex_q[$];
	logic [7:0]  st_cnt, se_cnt;
	logic [14:0] rad;

	function automatic longint unsigned poly_sin(longint unsigned x);
		longint unsigned x2, t;
		x2 = (x * x) >> 30;
		t = uvs_pkg::COEF9;
		t = uvs_pkg::COEF7 - ((t * x2) >> 30);
		t = uvs_pkg::COEF5 - ((t * x2) >> 30);
		t = uvs_pkg::COEF3 - ((t * x2) >> 30);
		t = uvs_pkg::COEF1 - ((t * x2) >> 30);
		t = (t * x) >> 30;
		return (t > uvs_pkg::Q30_ONE) ? longint'(uvs_pkg::Q30_ONE) : t;
	endfunction

	function automatic longint turn_sin(longint unsigned ph);
		longint unsigned q, r, x, m;
		ph = ph & (FULL - 1);
		q = (ph >> (ANG - 2)) & 3;
		r = ph & (QTR - 1);
		x = q[0] ? QTR - r : r;
		x = x << (32 - ANG);
		m = poly_sin(x);
		return q[1] ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned absval(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint q30_mul(longint a, longint b);
		longint unsigned p;
		p = (absval(a) * absval(b) + (64'd1 << 29)) >> 30;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic [15:0] q30_to_norm(longint v);
		longint s;
		s = longint'((absval(v) + (64'd1 << 15)) >> 16);
		if (v < 0) s = -s;
		return s[15:0];
	endfunction

	function automatic logic [15:0] q30_to_pos(longint v, longint unsigned r);
		longint s;
		s = longint'((r * absval(v) + (64'd1 << 29)) >> 30);
		if (v < 0) s = -s;
		return s[15:0];
	endfunction

	function automatic vertex_t vertex_for(logic [7:0] si, logic [7:0] sj);
		longint unsigned i, j, nst, nse, sec_ph, polar, st_ph, t;
		longint sin_st, cos_st, sin_se, cos_se, dx, dz;
		vertex_t v;
		i = si;
		j = sj;
		nst = (st_cnt < 2) ? 2 : st_cnt;
		nse = (se_cnt < 3) ? 3 : se_cnt;
		v = '0;
		if (i > nst || j > nse) begin
			v.bad = 1'b1;
			return v;
		end
		sec_ph = (j * FULL * 2 + nse) / (2 * nse);
		polar = (i * FULL + nst) / (2 * nst);
		st_ph = (QTR - polar) & (FULL - 1);
		sin_st = turn_sin(st_ph);
		cos_st = turn_sin(st_ph + QTR);
		sin_se = turn_sin(sec_ph);
		cos_se = turn_sin(sec_ph + QTR);
		dx = q30_mul(cos_st, cos_se);
		dz = q30_mul(cos_st, sin_se);
		v.px = q30_to_pos(dx, rad);
		v.py = q30_to_pos(sin_st, rad);
		v.pz = q30_to_pos(dz, rad);
		v.nx = q30_to_norm(dx);
		v.ny = q30_to_norm(sin_st);
		v.nz = q30_to_norm(dz);
		t = (j * 65536 + nse) / (2 * nse);
		v.u = t[15:0];
		t = (i * 65536 + nst) / (2 * nst);
		v.v = t[15:0];
		return v;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		vertex_t w;
		if (!arst_n) begin
			st_cnt = uvs_pkg::STACK_COUNT_RST;
			se_cnt = uvs_pkg::SECTOR_COUNT_RST;
			rad = uvs_pkg::RADIUS_RST;
			errors = 0;
			pending = 0;
		end else begin
			// result transfer: compare against the oldest expectation
			if (out_valid && !out_stall) begin
				if (vertex_q.size() == 0) begin
					report("unexpected vertex", pos_x, 16'h0);
				end else begin
					w = vertex_q.pop_front();
					if (pos_x !== w.px) report("pos_x", pos_x, w.px);
					if (pos_y !== w.py) report("pos_y", pos_y, w.py);
					if (pos_z !== w.pz) report("pos_z", pos_z, w.pz);
					if (norm_x !== w.nx) report("norm_x", norm_x, w.nx);
					if (norm_y !== w.ny) report("norm_y", norm_y, w.ny);
					if (norm_z !== w.nz) report("norm_z", norm_z, w.nz);
					if (tex_u !== w.u) report("tex_u", tex_u, w.u);
					if (tex_v !== w.v) report("tex_v", tex_v, w.v);
					if (bad_index !== w.bad) report("bad_index", {15'd0, bad_index}, {15'd0, w.bad});
				end
			end
			if (in_valid && !in_stall)
				vertex_q.insert(vertex_q.size(), vertex_for(stack_index, sector_index));
			if (cfg_wen) begin
				case (cfg_index)
					uvs_pkg::CFG_STACK_COUNT:  st_cnt = cfg_wdata[7:0];
					uvs_pkg::CFG_SECTOR_COUNT: se_cnt = cfg_wdata[7:0];
					uvs_pkg::CFG_RADIUS:       rad = cfg_wdata;
					default: ;
				endcase
			end
			pending = vertex_q.size();
		end
	end
endmodule

// File: test/tb_uv_sphere_vertex_generator_core.sv
module tb_uv_sphere_vertex_generator_core;
	timeunit 1ns;
	timeprecision 1ps;

	// wait after the last result before touching config or ending
	localparam int TAIL = 40;
	// cycles with no transfer at all before the watchdog gives up
	localparam int WATCHDOG = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [14:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  stack_index = '0;
	logic [7:0]  sector_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v;
	logic        bad_index;
	int          errors, pending;

	int src_idle_pct = 0;   // sender gap odds, percent
	int snk_stall_pct = 0;  // receiver stall odds, percent
	int idle_cnt = 0;

	// own copy of the counts, only used to aim stimulus
	int nst = 16, nse = 32;

	uv_sphere_vertex_generator_core u_top (.*);

	uvs_vertex_checker u_chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver side: random stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < snk_stall_pct);

	// watchdog: count cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG) begin
			$display("FAIL uv_sphere_vertex_generator_core");
			$finish;
		end
	end

	// one grid point transfer; called and returns at a rising edge
	task automatic send_point(int si, int sj);
		logic st;
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stack_index <= si[7:0];
		sector_index <= sj[7:0];
		do begin
			@(negedge clk);
			st = in_stall;
			@(posedge clk);
		end while (st);
	endtask

	// park the input, then wait for the pipeline to empty
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic write_reg(uvs_pkg::cfg_idx_t idx, int val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val[14:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_config(int sc, int ec, int r);
		drain();
		write_reg(uvs_pkg::CFG_STACK_COUNT, sc);
		write_reg(uvs_pkg::CFG_SECTOR_COUNT, ec);
		write_reg(uvs_pkg::CFG_RADIUS, r);
		// counts below their minimum act as the minimum
		nst = (sc < 2) ? 2 : sc;
		nse = (ec < 3) ? 3 : ec;
	endtask

	// corners of the grid, the poles, the seam column and the out-of-range cases
	task automatic directed_points();
		send_point(0, 0);
		send_point(nst, nse);
		send_point(0, nse);
		send_point(nst, 0);
		send_point(nst / 2, nse / 4);
		send_point(nst / 2, nse / 2);
		send_point(nst / 2, (3 * nse) / 4);
		send_point(nst / 4, 1);
		if (nst < 255) send_point(nst + 1, 0);
		if (nse < 255) send_point(0, nse + 1);
		send_point(255, 255);
		send_point(170, 85);
		send_point(85, 170);
	endtask

	task automatic random_points(int n);
		int k;
		for (k = 0; k < n; k++) begin
			if ($urandom_range(99) < 88)
				send_point($urandom_range(nst), $urandom_range(nse));
			else
				send_point($urandom_range(255), $urandom_range(255));
			// once in a while hold off until everything is back
			if (k == n / 2 && $urandom_range(3) == 0) begin
				in_valid <= 1'b0;
				do @(negedge clk); while (pending != 0);
				@(posedge clk);
			end
		end
	endtask

	task automatic run_phase(int sc, int ec, int r, int idle, int stall, int n);
		set_config(sc, ec, r);
		src_idle_pct = idle;
		snk_stall_pct = stall;
		directed_points();
		random_points(n);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults first, no register touched
		directed_points();
		random_points(60);

		run_phase(2, 3, 0, 0, 0, 60);
		run_phase(255, 255, 32767, 71, 0, 80);
		run_phase(0, 0, 256, 0, 71, 60);
		run_phase(1, 2, 12345, 9, 9, 60);
		run_phase($urandom_range(2, 255), $urandom_range(3, 255), $urandom_range(32767),
			71, 0, 80);
		run_phase($urandom_range(2, 40), $urandom_range(3, 40), $urandom_range(32767),
			0, 71, 80);
		run_phase($urandom_range(255), $urandom_range(255), $urandom_range(32767),
			0, 0, 80);
		run_phase(16, 32, 256, 9, 9, 60);

		// make sure the pause-until-drained case happened at least once
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		random_points(40);

		drain();
		if (errors == 0)
			$display("PASS uv_sphere_vertex_generator_core");
		else
			$display("FAIL uv_sphere_vertex_generator_core");
		$finish;
	end
endmodule
